@@ sv/asc_pkg.sv @@
// Shared types, widths and constants for the airspeed sensor conditioner.
// No dependencies; compiled first.
`default_nettype none
package asc_pkg;

  // field widths
  localparam int CODE_W  = 3;
  localparam int PRESS_W = 14;
  localparam int TEMP_W  = 11;
  localparam int STAT_W  = 2;
  localparam int DP_W    = 20;
  localparam int TK_W    = 15;
  localparam int CAS_W   = 18;
  localparam int TAS_W   = 19;
  localparam int CNT_W   = 12;
  localparam int SCALE_W = 14;

  // serial multiplier: A x B, one bit of B per cycle
  localparam int MUL_AW = 40;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW);

  // serial restoring divider: one quotient bit per cycle
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = $clog2(DIV_NW);

  // serial square root: one root bit per cycle
  localparam int SQ_IW = 48;
  localparam int SQ_RW = SQ_IW / 2;
  localparam int SQ_CW = $clog2(SQ_RW);

  // read codes
  localparam logic [CODE_W-1:0] CODE_OK     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_WARN_A = 3'd4;
  localparam logic [CODE_W-1:0] CODE_WARN_B = 3'd5;

  // status and alarm codes
  localparam logic [STAT_W-1:0] ST_MEASURED = 2'd0;
  localparam logic [STAT_W-1:0] ST_CALIB    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FAIL     = 2'd2;
  localparam logic [1:0] ALARM_OK   = 2'd0;
  localparam logic [1:0] ALARM_WARN = 2'd1;
  localparam logic [1:0] ALARM_ERR  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PRESET = 2'd0;
  localparam logic [1:0] REG_NSAMP  = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  localparam logic [CNT_W-1:0] NSAMP_MAX = 12'd4000;
  localparam logic [CNT_W-1:0] NSAMP_MIN = 12'd1;
  localparam logic [CNT_W-1:0] NSAMP_RST = 12'd400;
  localparam logic [SCALE_W-1:0] SCALE_RST = 14'd4096;

  // arithmetic constants
  localparam logic [20:0] DP_GAIN   = 21'd1103229;
  localparam logic [35:0] DP_RND    = 36'd32768;
  localparam logic [16:0] TK_GAIN   = 17'd64000;
  localparam logic [27:0] TK_OFS    = 28'd146177293;
  localparam logic [13:0] TK_DIVSR  = 14'd10235;
  localparam logic [20:0] P0_SIXT   = 21'd1621200;
  localparam logic [2:0]  SER_DIV0  = 3'd7;
  localparam logic [25:0] CAS_GAIN  = 26'd49865049;
  localparam logic [15:0] TAS_GAIN  = 16'd61772;
  localparam logic [40:0] CAS_RND   = 41'd2097152;
  localparam logic [56:0] TAS_RND   = 57'h10_0000_0000;
  localparam logic [4:0]  K_LAST    = 5'd16;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DP_MUL,
    S_TK_MUL,
    S_TK_DIV,
    S_X_DIV,
    S_M1_DIV,
    S_SER_ACC,
    S_SER_MUL,
    S_SER_SCL,
    S_SER_DIV,
    S_SQ_Y,
    S_CAS_MUL,
    S_SC_MUL,
    S_SQ_T,
    S_G_MUL,
    S_TAS_MUL,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ sv/asc_if.sv @@
// Valid/ready channel interfaces for reading words and result words.
// Depends on asc_pkg.
`default_nettype none
interface asc_in_if;
  logic                         valid;
  logic                         ready;
  logic [asc_pkg::CODE_W-1:0]   read_code;
  logic [asc_pkg::PRESS_W-1:0]  pressure_counts;
  logic [asc_pkg::TEMP_W-1:0]   temperature_counts;
  modport source (output valid, read_code, pressure_counts, temperature_counts,
                  input ready);
  modport sink (input valid, read_code, pressure_counts, temperature_counts,
                output ready);
endinterface

interface asc_out_if;
  logic                        valid;
  logic                        ready;
  logic [asc_pkg::STAT_W-1:0]  status;
  logic [1:0]                  alarm_level;
  logic                        connected;
  logic signed [asc_pkg::DP_W-1:0] diff_pressure;
  logic [asc_pkg::TK_W-1:0]    temperature_kelvin;
  logic [asc_pkg::CAS_W-1:0]   calibrated_speed;
  logic [asc_pkg::TAS_W-1:0]   true_speed;
  logic                        zero_learned;
  logic [asc_pkg::PRESS_W-1:0] learned_zero_value;
  modport source (output valid, status, alarm_level, connected, diff_pressure,
                  temperature_kelvin, calibrated_speed, true_speed, zero_learned,
                  learned_zero_value, input ready);
  modport sink (input valid, status, alarm_level, connected, diff_pressure,
                temperature_kelvin, calibrated_speed, true_speed, zero_learned,
                learned_zero_value, output ready);
endinterface
`default_nettype wire

@@ sv/asc_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on asc_pkg.
`default_nettype none
module asc_mul (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire [asc_pkg::MUL_AW-1:0]   a,
  input  wire [asc_pkg::MUL_BW-1:0]   b,
  output logic                        done,
  output logic [asc_pkg::MUL_PW-1:0]  prod
);
  localparam int AW = asc_pkg::MUL_AW;
  localparam int BW = asc_pkg::MUL_BW;
  localparam int PW = asc_pkg::MUL_PW;
  localparam int CW = asc_pkg::MUL_CW;

  logic [AW-1:0] a_r;
  logic [PW-1:0] p_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [AW:0]   sum;

  always_comb begin
    sum = {1'b0, p_r[PW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      p_r <= {sum, p_r[BW-1:1]};
    end else if (start) begin
      a_r <= a;
      p_r <= {{AW{1'b0}}, b};
    end
  end

  assign done = done_r;
  assign prod = p_r;
endmodule
`default_nettype wire

@@ sv/asc_div.sv @@
// Restoring divider, one quotient bit per cycle; the divisor is latched at start.
// Depends on asc_pkg.
`default_nettype none
module asc_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire [asc_pkg::DIV_NW-1:0]   num,
  input  wire [asc_pkg::DIV_DW-1:0]   den,
  output logic                        done,
  output logic [asc_pkg::DIV_NW-1:0]  quot
);
  localparam int NW = asc_pkg::DIV_NW;
  localparam int DW = asc_pkg::DIV_DW;
  localparam int CW = asc_pkg::DIV_CW;

  logic [NW-1:0] q_r;
  logic [DW-1:0] r_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {r_r, q_r[NW-1]};
    diff  = trial - {1'b0, d_r};
    ge    = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      q_r <= {q_r[NW-2:0], ge};
      r_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end else if (start) begin
      q_r <= num;
      r_r <= '0;
      d_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

@@ sv/asc_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on asc_pkg.
`default_nettype none
module asc_sqrt (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [asc_pkg::SQ_IW-1:0]   rad,
  output logic                       done,
  output logic [asc_pkg::SQ_RW-1:0]  root
);
  localparam int IW = asc_pkg::SQ_IW;
  localparam int RW = asc_pkg::SQ_RW;
  localparam int CW = asc_pkg::SQ_CW;
  localparam int MW = RW + 2;

  logic [IW-1:0] n_r;
  logic [MW-1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [MW+1:0] t;
  logic [MW+1:0] trial;
  logic [MW+1:0] diff;
  logic          ge;

  always_comb begin
    t     = {rem_r, n_r[IW-1:IW-2]};
    trial = {2'b00, root_r, 2'b01};
    diff  = t - trial;
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      n_r    <= {n_r[IW-3:0], 2'b00};
      rem_r  <= ge ? diff[MW-1:0] : t[MW-1:0];
      root_r <= {root_r[RW-2:0], ge};
    end else if (start) begin
      n_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

@@ sv/airspeed_sensor_conditioner.sv @@
// Airspeed sensor conditioner for a pitot differential-pressure probe. Takes one
// reading word (read code, 14-bit pressure count, 11-bit temperature count) and
// returns one result word. A failed read or a calibrating reading goes straight
// to the done state. A measured reading runs the pow(2/7) binomial series in 15
// update rounds, each using the shared bit-serial multiplier twice and the serial
// divider once, between a front end and the two square roots and the speed gains.
// One reading is in work at a time; the result sits in an output register, so the
// next reading is accepted while it waits. Registers over APB at 0x0 (preset
// zero point), 0x4 (calibration samples) and 0x8 (airspeed gain, Q2.12).
// Depends on asc_pkg, asc_if, asc_mul, asc_div, asc_sqrt.
`default_nettype none
module airspeed_sensor_conditioner #(
  parameter int FILTER_SHIFT_BITS = 5
) (
  input  wire         clk,
  input  wire         rst_n,
  asc_in_if.sink      in_ch,
  asc_out_if.source   out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int PW = asc_pkg::PRESS_W;
  localparam int FW = PW + FILTER_SHIFT_BITS;   // averaging filter width
  localparam int CW = asc_pkg::CNT_W;

  // ---------------- configuration registers ----------------
  logic [PW-1:0]                 preset_r;
  logic [CW-1:0]                 nsamp_r;
  logic [asc_pkg::SCALE_W-1:0]   scale_r;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      asc_pkg::REG_PRESET: prdata = 32'(preset_r);
      asc_pkg::REG_NSAMP:  prdata = 32'(nsamp_r);
      asc_pkg::REG_SCALE:  prdata = 32'(scale_r);
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- state ----------------
  asc_pkg::state_t state_r, state_nxt;
  logic            launch_r, launch_nxt;   // unit started for current state
  logic            out_valid_r;
  logic [CW-1:0]   calib_count_r;
  logic [FW-1:0]   avg_filter_r;
  logic [PW-1:0]   learned_zero_r;
  logic            learned_valid_r;

  // datapath
  logic [PW-1:0]   mag_r;
  logic            neg_r;
  logic [asc_pkg::TEMP_W-1:0] t_r;
  logic [18:0]     dmag_r;
  logic [28:0]     tkn_r;
  logic [asc_pkg::TK_W-1:0]   tk_r;
  logic [31:0]     x_r;
  logic [31:0]     m_r;
  logic [31:0]     y_r;
  logic [39:0]     pm_r;
  logic [4:0]      k_r;
  logic [23:0]     s_r;
  logic [33:0]     v_r;
  logic [39:0]     c_r;
  logic [15:0]     q_r;
  logic [15:0]     g_r;

  // held result word
  logic [asc_pkg::STAT_W-1:0] res_status_r;
  logic [1:0]      res_alarm_r;
  logic            res_conn_r;
  logic [asc_pkg::DP_W-1:0]  res_dp_r;
  logic [asc_pkg::TK_W-1:0]  res_tk_r;
  logic [asc_pkg::CAS_W-1:0] res_cas_r;
  logic [asc_pkg::TAS_W-1:0] res_tas_r;
  logic            res_zl_r;
  logic [PW-1:0]   res_lzv_r;

  // output register
  logic [asc_pkg::STAT_W-1:0] out_status_r;
  logic [1:0]      out_alarm_r;
  logic            out_conn_r;
  logic [asc_pkg::DP_W-1:0]  out_dp_r;
  logic [asc_pkg::TK_W-1:0]  out_tk_r;
  logic [asc_pkg::CAS_W-1:0] out_cas_r;
  logic [asc_pkg::TAS_W-1:0] out_tas_r;
  logic            out_zl_r;
  logic [PW-1:0]   out_lzv_r;

  // ---------------- shared serial units ----------------
  logic                         mul_start, div_start, sq_start;
  logic                         mul_done, div_done, sq_done;
  logic [asc_pkg::MUL_AW-1:0]   mul_a;
  logic [asc_pkg::MUL_BW-1:0]   mul_b;
  logic [asc_pkg::MUL_PW-1:0]   mul_p;
  logic [asc_pkg::DIV_NW-1:0]   div_n;
  logic [asc_pkg::DIV_DW-1:0]   div_d;
  logic [asc_pkg::DIV_NW-1:0]   div_q;
  logic [asc_pkg::SQ_IW-1:0]    sq_in;
  logic [asc_pkg::SQ_RW-1:0]    sq_root;

  asc_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod(mul_p));
  asc_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_n), .den(div_d),
                 .done(div_done), .quot(div_q));
  asc_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .rad(sq_in),
                   .done(sq_done), .root(sq_root));

  // ---------------- reading decode and calibration filter ----------------
  logic [PW-1:0]   cal_zp;
  logic [CW-1:0]   n_eff;
  logic [FW-1:0]   f_upd;
  logic [FW-1:0]   f_seed;
  logic [CW-1:0]   cnt_inc;
  logic            cal_finish;
  logic [PW-1:0]   lz_new;
  logic [PW:0]     dsub;
  logic            accept;
  logic            rd_fail;
  logic            out_free;

  always_comb begin
    cal_zp = (preset_r != '0) ? preset_r : (learned_valid_r ? learned_zero_r : '0);
    if (nsamp_r < asc_pkg::NSAMP_MIN)      n_eff = asc_pkg::NSAMP_MIN;
    else if (nsamp_r > asc_pkg::NSAMP_MAX) n_eff = asc_pkg::NSAMP_MAX;
    else                                   n_eff = nsamp_r;
    f_seed     = FW'(in_ch.pressure_counts) << FILTER_SHIFT_BITS;
    f_upd      = avg_filter_r - (avg_filter_r >> FILTER_SHIFT_BITS)
                 + FW'(in_ch.pressure_counts);
    cnt_inc    = calib_count_r + 1'b1;
    cal_finish = (calib_count_r != '0) && (cnt_inc > n_eff);
    lz_new     = f_upd[FW-1:FILTER_SHIFT_BITS];
    dsub       = {1'b0, in_ch.pressure_counts} - {1'b0, cal_zp};
    accept     = (state_r == asc_pkg::S_IDLE) && in_ch.valid;
    rd_fail    = (in_ch.read_code != asc_pkg::CODE_OK);
    out_free   = !out_valid_r || out_ch.ready;
  end

  // ---------------- sequencer ----------------
  // ser_* coefficients of the binomial series: (7k-2) and (7k+7)
  logic [7:0]      k7;
  logic [6:0]      coef_num, coef_den;
  logic            use_mul, use_div, use_sq, unit_done;
  asc_pkg::state_t after;

  always_comb begin
    k7       = ({3'b000, k_r} << 3) - {3'b000, k_r};
    coef_num = 7'(k7 - 8'd2);
    coef_den = 7'(k7 + 8'd7);
  end

  always_comb begin
    state_nxt  = state_r;
    launch_nxt = launch_r;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sq_start   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_n      = '0;
    div_d      = '0;
    sq_in      = '0;
    use_mul    = 1'b0;
    use_div    = 1'b0;
    use_sq     = 1'b0;
    after      = state_r;
    case (state_r)
      asc_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          if (rd_fail || cal_zp == '0) state_nxt = asc_pkg::S_DONE;
          else                         state_nxt = asc_pkg::S_DP_MUL;
        end
      end
      asc_pkg::S_DP_MUL: begin
        use_mul = 1'b1;
        mul_a   = 40'(asc_pkg::DP_GAIN);
        mul_b   = 32'(mag_r);
        after   = asc_pkg::S_TK_MUL;
      end
      asc_pkg::S_TK_MUL: begin
        use_mul = 1'b1;
        mul_a   = 40'(asc_pkg::TK_GAIN);
        mul_b   = 32'(t_r);
        after   = asc_pkg::S_TK_DIV;
      end
      asc_pkg::S_TK_DIV: begin
        use_div = 1'b1;
        div_n   = 56'(tkn_r);
        div_d   = 24'(asc_pkg::TK_DIVSR);
        after   = asc_pkg::S_X_DIV;
      end
      asc_pkg::S_X_DIV: begin
        use_div = 1'b1;
        div_n   = {5'b00000, dmag_r, 32'd0};
        div_d   = 24'(asc_pkg::P0_SIXT);
        after   = asc_pkg::S_M1_DIV;
      end
      asc_pkg::S_M1_DIV: begin
        use_div = 1'b1;
        div_n   = {23'd0, x_r, 1'b0};
        div_d   = 24'(asc_pkg::SER_DIV0);
        after   = asc_pkg::S_SER_ACC;
      end
      asc_pkg::S_SER_ACC: begin
        state_nxt = (k_r == asc_pkg::K_LAST) ? asc_pkg::S_SQ_Y : asc_pkg::S_SER_MUL;
      end
      asc_pkg::S_SER_MUL: begin
        use_mul = 1'b1;
        mul_a   = 40'(m_r);
        mul_b   = x_r;
        after   = asc_pkg::S_SER_SCL;
      end
      asc_pkg::S_SER_SCL: begin
        use_mul = 1'b1;
        mul_a   = pm_r;
        mul_b   = 32'(coef_num);
        after   = asc_pkg::S_SER_DIV;
      end
      asc_pkg::S_SER_DIV: begin
        use_div = 1'b1;
        div_n   = 56'(pm_r);
        div_d   = 24'(coef_den);
        after   = asc_pkg::S_SER_ACC;
      end
      asc_pkg::S_SQ_Y: begin
        use_sq = 1'b1;
        sq_in  = {y_r[27:0], 20'd0};
        after  = asc_pkg::S_CAS_MUL;
      end
      asc_pkg::S_CAS_MUL: begin
        use_mul = 1'b1;
        mul_a   = 40'(asc_pkg::CAS_GAIN);
        mul_b   = 32'(s_r);
        after   = asc_pkg::S_SC_MUL;
      end
      asc_pkg::S_SC_MUL: begin
        use_mul = 1'b1;
        mul_a   = 40'(v_r);
        mul_b   = 32'(scale_r);
        after   = asc_pkg::S_SQ_T;
      end
      asc_pkg::S_SQ_T: begin
        use_sq = 1'b1;
        sq_in  = {17'd0, tk_r, 16'd0};
        after  = asc_pkg::S_G_MUL;
      end
      asc_pkg::S_G_MUL: begin
        use_mul = 1'b1;
        mul_a   = 40'(asc_pkg::TAS_GAIN);
        mul_b   = 32'(q_r);
        after   = asc_pkg::S_TAS_MUL;
      end
      asc_pkg::S_TAS_MUL: begin
        use_mul = 1'b1;
        mul_a   = c_r;
        mul_b   = 32'(g_r);
        after   = asc_pkg::S_DONE;
      end
      asc_pkg::S_DONE: begin
        if (out_free) state_nxt = asc_pkg::S_IDLE;
      end
      default: state_nxt = asc_pkg::S_IDLE;
    endcase

    // launch the unit once, then wait for its done pulse
    unit_done = (use_mul && mul_done) || (use_div && div_done) || (use_sq && sq_done);
    if (use_mul || use_div || use_sq) begin
      if (!launch_r) begin
        mul_start  = use_mul;
        div_start  = use_div;
        sq_start   = use_sq;
        launch_nxt = 1'b1;
      end else if (unit_done) begin
        launch_nxt = 1'b0;
        state_nxt  = after;
      end
    end
  end

  logic fire;
  assign fire = launch_r && unit_done;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= asc_pkg::S_IDLE;
      launch_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      preset_r        <= '0;
      nsamp_r         <= asc_pkg::NSAMP_RST;
      scale_r         <= asc_pkg::SCALE_RST;
      calib_count_r   <= '0;
      avg_filter_r    <= '0;
      learned_zero_r  <= '0;
      learned_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
      if (state_r == asc_pkg::S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)                       out_valid_r <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          asc_pkg::REG_PRESET: preset_r <= pwdata[PW-1:0];
          asc_pkg::REG_NSAMP:  nsamp_r  <= pwdata[CW-1:0];
          asc_pkg::REG_SCALE:  scale_r  <= pwdata[asc_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      // calibration filter runs on good readings with no zero point
      if (accept && !rd_fail && cal_zp == '0) begin
        if (calib_count_r == '0) begin
          avg_filter_r  <= f_seed;
          calib_count_r <= CW'(1);
        end else begin
          avg_filter_r <= f_upd;
          if (cal_finish) begin
            learned_zero_r  <= lz_new;
            learned_valid_r <= 1'b1;
            calib_count_r   <= '0;
          end else begin
            calib_count_r <= cnt_inc;
          end
        end
      end
    end
  end

  // ---------------- datapath registers ----------------
  logic [35:0] dp_sum;
  logic [40:0] cas_sum;
  logic [56:0] tas_sum;
  logic [32:0] y_add;

  always_comb begin
    dp_sum  = {1'b0, mul_p[34:0]} + asc_pkg::DP_RND;
    cas_sum = {1'b0, mul_p[47:8]} + asc_pkg::CAS_RND;
    tas_sum = {1'b0, mul_p[55:0]} + asc_pkg::TAS_RND;
    y_add   = {1'b0, y_r} + {1'b0, m_r};
  end

  always_ff @(posedge clk) begin
    case (state_r)
      asc_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          mag_r <= dsub[PW] ? PW'(-dsub) : dsub[PW-1:0];
          neg_r <= dsub[PW];
          t_r   <= in_ch.temperature_counts;
          res_dp_r  <= '0;
          res_tk_r  <= '0;
          res_cas_r <= '0;
          res_tas_r <= '0;
          res_zl_r  <= 1'b0;
          res_lzv_r <= '0;
          if (rd_fail) begin
            res_status_r <= asc_pkg::ST_FAIL;
            res_conn_r   <= 1'b0;
            res_alarm_r  <= (in_ch.read_code == asc_pkg::CODE_WARN_A ||
                             in_ch.read_code == asc_pkg::CODE_WARN_B)
                            ? asc_pkg::ALARM_WARN : asc_pkg::ALARM_ERR;
          end else if (cal_zp == '0) begin
            res_status_r <= asc_pkg::ST_CALIB;
            res_conn_r   <= 1'b1;
            res_alarm_r  <= asc_pkg::ALARM_WARN;
            if (cal_finish) begin
              res_zl_r  <= 1'b1;
              res_lzv_r <= lz_new;
            end
          end else begin
            res_status_r <= asc_pkg::ST_MEASURED;
            res_conn_r   <= 1'b1;
            res_alarm_r  <= asc_pkg::ALARM_OK;
          end
        end
      end
      asc_pkg::S_DP_MUL: if (fire) dmag_r <= dp_sum[34:16];
      asc_pkg::S_TK_MUL: if (fire) tkn_r <= 29'(mul_p[26:0]) + 29'(asc_pkg::TK_OFS);
      asc_pkg::S_TK_DIV: if (fire) tk_r <= div_q[asc_pkg::TK_W-1:0];
      asc_pkg::S_X_DIV:  if (fire) x_r <= div_q[31:0];
      asc_pkg::S_M1_DIV: begin
        if (fire) begin
          m_r <= div_q[31:0];
          y_r <= '0;
          k_r <= 5'd1;
        end
      end
      asc_pkg::S_SER_ACC: begin
        // odd terms add, even terms subtract with a floor at zero
        if (k_r[0]) y_r <= y_add[31:0];
        else        y_r <= (y_r >= m_r) ? (y_r - m_r) : '0;
      end
      asc_pkg::S_SER_MUL: if (fire) pm_r <= mul_p[71:32];
      asc_pkg::S_SER_SCL: if (fire) pm_r <= mul_p[39:0];
      asc_pkg::S_SER_DIV: begin
        if (fire) begin
          m_r <= div_q[31:0];
          k_r <= k_r + 1'b1;
        end
      end
      asc_pkg::S_SQ_Y:    if (fire) s_r <= sq_root;
      asc_pkg::S_CAS_MUL: if (fire) v_r <= mul_p[49:16];
      asc_pkg::S_SC_MUL: begin
        if (fire) begin
          c_r       <= mul_p[47:8];
          res_cas_r <= cas_sum[40] ? {asc_pkg::CAS_W{1'b1}} : cas_sum[39:22];
        end
      end
      asc_pkg::S_SQ_T:  if (fire) q_r <= sq_root[15:0];
      asc_pkg::S_G_MUL: if (fire) g_r <= mul_p[31:16];
      asc_pkg::S_TAS_MUL: begin
        if (fire) begin
          res_tas_r <= tas_sum[56] ? {asc_pkg::TAS_W{1'b1}} : tas_sum[55:37];
          res_tk_r  <= tk_r;
          res_dp_r  <= neg_r ? (20'd0 - {1'b0, dmag_r}) : {1'b0, dmag_r};
        end
      end
      asc_pkg::S_DONE: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_alarm_r  <= res_alarm_r;
          out_conn_r   <= res_conn_r;
          out_dp_r     <= res_dp_r;
          out_tk_r     <= res_tk_r;
          out_cas_r    <= res_cas_r;
          out_tas_r    <= res_tas_r;
          out_zl_r     <= res_zl_r;
          out_lzv_r    <= res_lzv_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready               = (state_r == asc_pkg::S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.alarm_level        = out_alarm_r;
  assign out_ch.connected          = out_conn_r;
  assign out_ch.diff_pressure      = out_dp_r;
  assign out_ch.temperature_kelvin = out_tk_r;
  assign out_ch.calibrated_speed   = out_cas_r;
  assign out_ch.true_speed         = out_tas_r;
  assign out_ch.zero_learned       = out_zl_r;
  assign out_ch.learned_zero_value = out_lzv_r;
endmodule
`default_nettype wire

@@ sv/asc_checker.sv @@
// Port-level assertions for the airspeed sensor conditioner, plus its bind.
// Depends on asc_pkg and airspeed_sensor_conditioner.
`default_nettype none
module asc_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [asc_pkg::STAT_W-1:0]    status,
  input wire [1:0]                    alarm_level,
  input wire                          connected,
  input wire [asc_pkg::CAS_W-1:0]     calibrated_speed,
  input wire [asc_pkg::TAS_W-1:0]     true_speed,
  input wire                          zero_learned
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second reading taken while one is in work");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == asc_pkg::ST_FAIL |->
      !connected && calibrated_speed == '0 && true_speed == '0 && !zero_learned)
    else $error("failed read carries data");

  a_learned_calib: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_learned |->
      status == asc_pkg::ST_CALIB && alarm_level == asc_pkg::ALARM_WARN)
    else $error("zero learned outside calibration");

  a_measured_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == asc_pkg::ST_MEASURED |->
      connected && alarm_level == asc_pkg::ALARM_OK)
    else $error("measured word with bad alarm or link");
endmodule

bind airspeed_sensor_conditioner asc_checker u_asc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .alarm_level      (out_ch.alarm_level),
  .connected        (out_ch.connected),
  .calibrated_speed (out_ch.calibrated_speed),
  .true_speed       (out_ch.true_speed),
  .zero_learned     (out_ch.zero_learned)
);
`default_nettype wire

@@ tb/asc_scoreboard.sv @@
// Checker for the airspeed sensor conditioner: watches the reading and result
// channels and the register port, predicts each result word and compares.
// Depends on asc_pkg and asc_if.
`default_nettype none
module asc_scoreboard (
  input  wire        clk,
  input  wire        rst_n,
  asc_in_if.sink     rd_mon,
  asc_out_if.sink    res_mon,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire        pready,
  input  wire [3:0]  paddr,
  input  wire [31:0] pwdata,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import asc_pkg::*;

  localparam int SHIFT = 5;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [1:0]            alarm;
    logic                  conn;
    logic [DP_W-1:0]       dp;
    logic [TK_W-1:0]       tk;
    logic [CAS_W-1:0]      cas;
    logic [TAS_W-1:0]      tas;
    logic                  zl;
    logic [PRESS_W-1:0]    lz;
  } result_t;

  result_t expected_results[$];

  // register shadows
  logic [13:0] zero_preset;
  logic [11:0] nsamp;
  logic [13:0] gain_q12;
  // block state copy
  logic [11:0] cal_cnt;
  logic [31:0] filt;
  logic [13:0] zero_lrn;

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // (1+x)^(2/7) - 1, binomial series, Q32
  function automatic longint unsigned pow27m1(longint unsigned x);
    longint unsigned m, y;
    m = (x * 2) / 7;
    y = 0;
    for (int k = 1; k <= 16; k++) begin
      if (k % 2 == 1) y += m;
      else y = (y >= m) ? y - m : 0;
      m = ((m * x) >> 32) * (7 * k - 2) / (7 * k + 7);
    end
    return y;
  endfunction

  function automatic result_t predict_reading(logic [2:0] code, logic [13:0] p,
                                              logic [10:0] t);
    result_t r;
    logic [13:0] zp;
    logic [11:0] n;
    int d;
    longint unsigned mag, dmag, tk, x, y, s, v, c, cas, q, g, tas;
    r = '0;
    if (code != CODE_OK) begin
      r.status = ST_FAIL;
      r.alarm = (code == CODE_WARN_A || code == CODE_WARN_B) ? ALARM_WARN : ALARM_ERR;
      return r;
    end
    zp = (zero_preset != 0) ? zero_preset : zero_lrn;
    r.conn = 1'b1;
    if (zp == 0) begin
      n = nsamp;
      if (n < NSAMP_MIN) n = NSAMP_MIN;
      if (n > NSAMP_MAX) n = NSAMP_MAX;
      r.status = ST_CALIB;
      r.alarm = ALARM_WARN;
      if (cal_cnt == 0) begin
        filt = 32'(p) << SHIFT;
        cal_cnt = 1;
      end else begin
        filt = filt - (filt >> SHIFT) + 32'(p);
        cal_cnt = cal_cnt + 1'b1;
        if (cal_cnt > n) begin
          zero_lrn = 14'(filt >> SHIFT);
          cal_cnt = 0;
          r.zl = 1'b1;
          r.lz = zero_lrn;
        end
      end
      return r;
    end
    d = int'(p) - int'(zp);
    mag = (d < 0) ? -d : d;
    dmag = (mag * 1103229 + 32768) >> 16;
    tk = (64000 * longint'(t) + 146177293) / 10235;
    x = (dmag << 32) / 1621200;
    y = pow27m1(x);
    s = sqrt_floor(y << 20);
    v = (s * 49865049) >> 16;
    c = (v * gain_q12) >> 8;
    cas = (c + (64'd1 << 21)) >> 22;
    q = sqrt_floor(tk << 16);
    g = (q * 61772) >> 16;
    tas = (c * g + (64'd1 << 36)) >> 37;
    if (cas > 262143) cas = 262143;
    if (tas > 524287) tas = 524287;
    r.status = ST_MEASURED;
    r.alarm = ALARM_OK;
    r.dp = (d < 0) ? DP_W'(-dmag) : DP_W'(dmag);
    r.tk = TK_W'(tk);
    r.cas = CAS_W'(cas);
    r.tas = TAS_W'(tas);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst_n) begin
      zero_preset <= 0;
      nsamp <= NSAMP_RST;
      gain_q12 <= SCALE_RST;
      cal_cnt <= 0;
      filt <= 0;
      zero_lrn <= 0;
      expected_results.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PRESET: zero_preset = pwdata[13:0];
          REG_NSAMP:  nsamp = pwdata[11:0];
          REG_SCALE:  gain_q12 = pwdata[13:0];
          default: ;
        endcase
      end
      if (rd_mon.valid && rd_mon.ready)
        expected_results.push_back(predict_reading(rd_mon.read_code,
          rd_mon.pressure_counts, rd_mon.temperature_counts));
      if (res_mon.valid && res_mon.ready) begin
        got = {res_mon.status, res_mon.alarm_level, res_mon.connected,
               res_mon.diff_pressure, res_mon.temperature_kelvin,
               res_mon.calibrated_speed, res_mon.true_speed,
               res_mon.zero_learned, res_mon.learned_zero_value};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, got %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected st=%0d al=%0d con=%0d dp=%0d tk=%0d cas=%0d tas=%0d zl=%0d lz=%0d",
                     $time, exp_r.status, exp_r.alarm, exp_r.conn, $signed(exp_r.dp),
                     exp_r.tk, exp_r.cas, exp_r.tas, exp_r.zl, exp_r.lz);
            $display("%0t:          actual   st=%0d al=%0d con=%0d dp=%0d tk=%0d cas=%0d tas=%0d zl=%0d lz=%0d",
                     $time, got.status, got.alarm, got.conn, $signed(got.dp),
                     got.tk, got.cas, got.tas, got.zl, got.lz);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/tb_airspeed_sensor_conditioner.sv @@
// Top of the airspeed sensor conditioner testbench: clock, reset, reading and
// register stimulus, random result back-pressure, verdict.
// Depends on asc_pkg, asc_if, asc_scoreboard and the block itself.
`default_nettype none
module tb_airspeed_sensor_conditioner;
  timeunit 1ns;
  timeprecision 1ps;
  import asc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          send_idle_pct = 0;   // chance of a gap cycle before a word
  int          recv_stall_pct = 0;  // chance of ready low per cycle

  asc_in_if  rd_ch ();
  asc_out_if res_ch ();

  airspeed_sensor_conditioner i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(rd_ch), .out_ch(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  asc_scoreboard i_chk (
    .clk(clk), .rst_n(rst_n), .rd_mon(rd_ch), .res_mon(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    rd_ch.valid = 1'b0;
    rd_ch.read_code = '0;
    rd_ch.pressure_counts = '0;
    rd_ch.temperature_counts = '0;
    res_ch.ready = 1'b0;
  end

  // result back-pressure, changes on the falling edge
  always @(negedge clk)
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // one reading word; returns at the edge where it was taken
  task automatic send_reading(input logic [2:0] code, input logic [13:0] p,
                              input logic [10:0] t);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      rd_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    rd_ch.valid = 1'b1;
    rd_ch.read_code = code;
    rd_ch.pressure_counts = p;
    rd_ch.temperature_counts = t;
    @(posedge clk);
    while (!rd_ch.ready) @(posedge clk);
  endtask

  // drain all results and wait out a margin; block is idle after that
  task automatic wait_drained();
    @(negedge clk);
    rd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // APB write: setup then access, only while idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_drained();
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // random word: mostly good reads, some failure codes including 7
  task automatic send_random();
    logic [2:0] code;
    code = ($urandom_range(99) < 85) ? CODE_OK : 3'($urandom_range(7, 1));
    send_reading(code, 14'($urandom), 11'($urandom));
  endtask

  initial begin
    logic [13:0] zp;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed ----
    // N of 0 behaves as 1; a learned zero of 0 restarts calibration
    write_reg(REG_NSAMP, 32'd0);
    for (int c = 1; c <= 7; c++) send_reading(3'(c), 14'h3fff, 11'h7ff);
    send_reading(CODE_OK, 14'd0, 11'd0);
    send_reading(CODE_OK, 14'd0, 11'd0);      // learns zero 0
    send_reading(CODE_OK, 14'h3fff, 11'd5);   // calibration again
    send_reading(3'd4, 14'd0, 11'd0);         // failure leaves state alone
    send_reading(CODE_OK, 14'h3fff, 11'd5);   // learns 16383
    send_reading(CODE_OK, 14'd0, 11'd0);      // largest negative pressure
    send_reading(CODE_OK, 14'h3fff, 11'h7ff); // zero pressure
    // preset low, full gain: largest positive pressure, saturation
    write_reg(REG_PRESET, 32'd1);
    write_reg(REG_SCALE, 32'd16383);
    send_reading(CODE_OK, 14'h3fff, 11'h7ff);
    send_reading(CODE_OK, 14'h3fff, 11'd0);
    send_reading(CODE_OK, 14'd1, 11'd1024);
    write_reg(REG_PRESET, 32'd16383);
    write_reg(REG_SCALE, 32'd0);
    send_reading(CODE_OK, 14'd0, 11'h7ff);
    // clearing the preset falls back to the learned zero of 16383, so no calibration runs here
    write_reg(REG_PRESET, 32'd0);
    write_reg(REG_NSAMP, 32'd4000);
    write_reg(REG_SCALE, 32'd4096);
    repeat (4) send_reading(CODE_OK, 14'($urandom), 11'($urandom));
    write_reg(REG_NSAMP, 32'd2);
    send_reading(CODE_OK, 14'd200, 11'd300);
    send_reading(CODE_OK, 14'd9000, 11'd300);
    // N above its range with a preset zero in use
    write_reg(REG_NSAMP, 32'd4095);
    write_reg(REG_PRESET, 32'd8192);
    send_reading(CODE_OK, 14'd8192, 11'd700);

    // ---- random phases: no idling, sender, receiver, both ----
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // half the phases clear the preset and use the learned zero instead
      zp = (ph % 2 == 0) ? 14'd0 : 14'($urandom);
      write_reg(REG_PRESET, {18'd0, zp});
      write_reg(REG_NSAMP, 32'($urandom_range(12, 1)));
      write_reg(REG_SCALE, (ph == 3) ? 32'd16383 : 32'($urandom_range(16383)));
      for (int i = 0; i < 135; i++) begin
        if ($urandom_range(99) == 0) wait_drained(); // sender holds off
        send_random();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog for about 1100 readings, most of them measured, with ample margin
  initial begin
    #400_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
